// File: src/jvmoss_pkg.sv
// Package with the command codes, status codes and slot type of the operand stack unit.
package jvmoss_pkg;

	typedef enum logic [3:0] {
		CMD_PUSH    = 4'd0,
		CMD_POP     = 4'd1,
		CMD_POP2    = 4'd2,
		CMD_DUP     = 4'd3,
		CMD_DUP_X1  = 4'd4,
		CMD_DUP_X2  = 4'd5,
		CMD_DUP2    = 4'd6,
		CMD_DUP2_X1 = 4'd7,
		CMD_DUP2_X2 = 4'd8,
		CMD_SWAP    = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_UNDERFLOW = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	localparam int VALUE_W = 64;
	localparam int CMD_W   = 4;
	localparam int DEPTH_W = 5;
	localparam int DATA_W  = 72;

	// Source of a rewritten slot: one of the top four old slots or the pushed value.
	typedef enum logic [2:0] {
		SRC_V1   = 3'd0,
		SRC_V2   = 3'd1,
		SRC_V3   = 3'd2,
		SRC_V4   = 3'd3,
		SRC_PUSH = 3'd4
	} src_t;

	localparam int CAND_N = 5;
	localparam int PICK_N = 6;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               wide;
	} slot_t;

endpackage

// File: src/jvm_operand_stack_shuffle_top.sv
// Operand stack unit with a shifting register stack for the JVM stack shuffle commands.
// An accepted transaction is held in a command register, then its result is registered.
// Throughput: one transaction per cycle unless the output stalls; the stack is a row of
// slot registers that shifts by up to two places and rewrites up to six top slots.
// Reset clears the stack pointer and the valid flags of both stages; slot contents
// are not cleared and are only read once written.
module jvm_operand_stack_shuffle_top
	import jvmoss_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// Fields from bit 0: command[3:0], push_value[67:4], zero fill.
	input  logic [DATA_W-1:0] s_axis_tdata,
	// Fields from bit 0: push_is_wide.
	input  logic              s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// Fields from bit 0: top_value[63:0], stack_depth[68:64], status[70:69], zero fill.
	output logic [DATA_W-1:0] m_axis_tdata,
	// Fields from bit 0: top_is_wide.
	output logic              m_axis_tuser
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SUMW = SPW + 2;
	localparam int DW = (SPW > DEPTH_W) ? SPW : DEPTH_W;

	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               wide_s1;

	logic               res_valid_q;
	logic [VALUE_W-1:0] top_value_q;
	logic               top_wide_q;
	logic [DEPTH_W-1:0] depth_q;
	status_t            status_q;

	slot_t              stack_q [STACK_DEPTH];
	logic [SPW-1:0]     sp_q;

	logic               res_ready;
	logic               s1_ready;
	logic               fire_s1;

	slot_t              cand [CAND_N];
	logic [3:0]         wide_eff;
	src_t               pick [PICK_N];
	logic [2:0]         need;
	logic [2:0]         n_put;
	logic               cmd_ok;
	logic [2:0]         sh;
	slot_t              stack_d [STACK_DEPTH];
	logic [SUMW-1:0]    sum;
	status_t            status_d;
	logic               commit;
	logic [SPW-1:0]     sp_after;
	slot_t              top_after;
	logic [DW-1:0]      sp_ext;

	assign res_ready = !res_valid_q || m_axis_tready;
	assign s1_ready = !valid_s1 || res_ready;
	assign s_axis_tready = s1_ready;
	assign fire_s1 = valid_s1 && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tdata[CMD_W-1:0];
			value_s1 <= s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];
			wide_s1 <= s_axis_tuser;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cand[i] = stack_q[i];
			wide_eff[i] = stack_q[i].wide && (sp_q > SPW'(i));
		end
		cand[SRC_PUSH].value = value_s1;
		cand[SRC_PUSH].wide = wide_s1;
	end

	// Picks are listed from the new top slot downward.
	always_comb begin
		need = 3'd0;
		n_put = 3'd0;
		cmd_ok = 1'b1;
		for (int j = 0; j < PICK_N; j++) begin
			pick[j] = SRC_V1;
		end
		unique case (cmd_s1)
			CMD_PUSH: begin
				n_put = 3'd1;
				pick[0] = SRC_PUSH;
			end
			CMD_POP: begin
				need = 3'd1;
			end
			CMD_POP2: begin
				need = wide_eff[0] ? 3'd1 : 3'd2;
			end
			CMD_DUP: begin
				need = 3'd1;
				n_put = 3'd2;
			end
			CMD_DUP_X1: begin
				need = 3'd2;
				n_put = 3'd3;
				pick[1] = SRC_V2;
			end
			CMD_DUP_X2: begin
				if (wide_eff[1]) begin
					need = 3'd2;
					n_put = 3'd3;
					pick[1] = SRC_V2;
				end else begin
					need = 3'd3;
					n_put = 3'd4;
					pick[1] = SRC_V2;
					pick[2] = SRC_V3;
				end
			end
			CMD_DUP2: begin
				if (wide_eff[0]) begin
					need = 3'd1;
					n_put = 3'd2;
				end else begin
					need = 3'd2;
					n_put = 3'd4;
					pick[1] = SRC_V2;
					pick[3] = SRC_V2;
				end
			end
			CMD_DUP2_X1: begin
				if (wide_eff[0]) begin
					need = 3'd2;
					n_put = 3'd3;
					pick[1] = SRC_V2;
				end else begin
					need = 3'd3;
					n_put = 3'd5;
					pick[1] = SRC_V2;
					pick[2] = SRC_V3;
					pick[4] = SRC_V2;
				end
			end
			CMD_DUP2_X2: begin
				if (wide_eff[0] && wide_eff[1]) begin
					need = 3'd2;
					n_put = 3'd3;
					pick[1] = SRC_V2;
				end else if (wide_eff[0]) begin
					need = 3'd3;
					n_put = 3'd4;
					pick[1] = SRC_V2;
					pick[2] = SRC_V3;
				end else if (wide_eff[2]) begin
					need = 3'd3;
					n_put = 3'd5;
					pick[1] = SRC_V2;
					pick[2] = SRC_V3;
					pick[4] = SRC_V2;
				end else begin
					need = 3'd4;
					n_put = 3'd6;
					pick[1] = SRC_V2;
					pick[2] = SRC_V3;
					pick[3] = SRC_V4;
					pick[5] = SRC_V2;
				end
			end
			CMD_SWAP: begin
				need = 3'd2;
				n_put = 3'd2;
				pick[0] = SRC_V2;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// The shift code is two plus the number of slots the stack shrinks by.
	assign sh = need - n_put + 3'd2;

	always_comb begin
		for (int j = 0; j < STACK_DEPTH; j++) begin
			unique case (sh)
				3'd0: stack_d[j] = stack_q[(j >= 2) ? j - 2 : j];
				3'd1: stack_d[j] = stack_q[(j >= 1) ? j - 1 : j];
				3'd3: stack_d[j] = stack_q[(j + 1 < STACK_DEPTH) ? j + 1 : j];
				3'd4: stack_d[j] = stack_q[(j + 2 < STACK_DEPTH) ? j + 2 : j];
				default: stack_d[j] = stack_q[j];
			endcase
		end
		for (int j = 0; j < PICK_N; j++) begin
			if (3'(j) < n_put) begin
				stack_d[j] = cand[pick[j]];
			end
		end
	end

	assign sum = SUMW'(sp_q) + SUMW'(n_put) - SUMW'(need);

	always_comb begin
		status_d = STATUS_OK;
		if (cmd_ok) begin
			priority if (SUMW'(need) > SUMW'(sp_q)) begin
				status_d = STATUS_UNDERFLOW;
			end else if (sum > SUMW'(STACK_DEPTH)) begin
				status_d = STATUS_OVERFLOW;
			end
		end
	end

	assign commit = cmd_ok && (status_d == STATUS_OK);
	assign sp_after = commit ? sum[SPW-1:0] : sp_q;
	assign top_after = commit ? stack_d[0] : stack_q[0];
	assign sp_ext = DW'(sp_after);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire_s1 && commit) begin
				sp_q <= sum[SPW-1:0];
			end
			if (res_ready) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (commit) begin
				for (int j = 0; j < STACK_DEPTH; j++) begin
					stack_q[j] <= stack_d[j];
				end
			end
			top_value_q <= (sp_after != '0) ? top_after.value : '0;
			top_wide_q <= (sp_after != '0) ? top_after.wide : 1'b0;
			depth_q <= sp_ext[DEPTH_W-1:0];
			status_q <= status_d;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tuser = top_wide_q;
	assign m_axis_tdata = {1'b0, status_q, depth_q, top_value_q};

endmodule

// File: tb/sv/jvm_operand_stack_shuffle_checker.sv
`timescale 1ns / 1ps
// Checker that tracks the operand stack, predicts every result and compares the output stream.
module jvm_operand_stack_shuffle_checker
	import jvmoss_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	// Fields from bit 0: command[3:0], push_value[67:4], zero fill.
	input  logic [DATA_W-1:0] s_axis_tdata,
	// Fields from bit 0: push_is_wide.
	input  logic              s_axis_tuser,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// Fields from bit 0: top_value[63:0], stack_depth[68:64], status[70:69], zero fill.
	input  logic [DATA_W-1:0] m_axis_tdata,
	// Fields from bit 0: top_is_wide.
	input  logic              m_axis_tuser,
	output int                error_count,
	output int                pending_count
);

	localparam int ORDER_W = 3 * PICK_N;

	typedef struct {
		logic [VALUE_W-1:0] top_value;
		logic               top_is_wide;
		logic [DEPTH_W-1:0] stack_depth;
		status_t            status;
	} stack_view_t;

	slot_t       stack_slots [STACK_DEPTH];
	int unsigned stack_ptr = 0;
	stack_view_t expected_views [$];
	int          mismatches = 0;

	assign error_count = mismatches;

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%t: %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic stack_view_t execute_command(input logic [CMD_W-1:0] code,
			input slot_t pushed);
		slot_t                  cand [CAND_N];
		logic [PICK_N-1:0][2:0] order;
		int unsigned            need;
		int unsigned            count;
		int unsigned            base;
		bit                     known;
		stack_view_t            view;
		for (int k = 0; k < CAND_N - 1; k++) begin
			cand[k] = '0;
			if (k < stack_ptr)
				cand[k] = stack_slots[stack_ptr - 1 - k];
		end
		cand[SRC_PUSH] = pushed;
		known = 1'b1;
		need = 0;
		count = 0;
		order = '0;
		view.status = STATUS_OK;
		// The new top slots are listed from the bottom up, so the top lands in element 0.
		case (code)
			CMD_PUSH: begin
				need = 0; count = 1; order = ORDER_W'(SRC_PUSH);
			end
			CMD_POP: need = 1;
			CMD_POP2: need = cand[SRC_V1].wide ? 1 : 2;
			CMD_DUP: begin
				need = 1; count = 2; order = ORDER_W'({SRC_V1, SRC_V1});
			end
			CMD_DUP_X1: begin
				need = 2; count = 3; order = ORDER_W'({SRC_V1, SRC_V2, SRC_V1});
			end
			CMD_DUP_X2: begin
				if (cand[SRC_V2].wide) begin
					need = 2; count = 3; order = ORDER_W'({SRC_V1, SRC_V2, SRC_V1});
				end else begin
					need = 3; count = 4;
					order = ORDER_W'({SRC_V1, SRC_V3, SRC_V2, SRC_V1});
				end
			end
			CMD_DUP2: begin
				if (cand[SRC_V1].wide) begin
					need = 1; count = 2; order = ORDER_W'({SRC_V1, SRC_V1});
				end else begin
					need = 2; count = 4;
					order = ORDER_W'({SRC_V2, SRC_V1, SRC_V2, SRC_V1});
				end
			end
			CMD_DUP2_X1: begin
				if (cand[SRC_V1].wide) begin
					need = 2; count = 3; order = ORDER_W'({SRC_V1, SRC_V2, SRC_V1});
				end else begin
					need = 3; count = 5;
					order = ORDER_W'({SRC_V2, SRC_V1, SRC_V3, SRC_V2, SRC_V1});
				end
			end
			CMD_DUP2_X2: begin
				if (cand[SRC_V1].wide && cand[SRC_V2].wide) begin
					need = 2; count = 3; order = ORDER_W'({SRC_V1, SRC_V2, SRC_V1});
				end else if (cand[SRC_V1].wide) begin
					need = 3; count = 4;
					order = ORDER_W'({SRC_V1, SRC_V3, SRC_V2, SRC_V1});
				end else if (cand[SRC_V3].wide) begin
					need = 3; count = 5;
					order = ORDER_W'({SRC_V2, SRC_V1, SRC_V3, SRC_V2, SRC_V1});
				end else begin
					need = 4; count = 6;
					order = ORDER_W'({SRC_V2, SRC_V1, SRC_V4, SRC_V3, SRC_V2, SRC_V1});
				end
			end
			CMD_SWAP: begin
				need = 2; count = 2; order = ORDER_W'({SRC_V1, SRC_V2});
			end
			default: known = 1'b0;
		endcase
		if (known) begin
			if (need > stack_ptr)
				view.status = STATUS_UNDERFLOW;
			else if (stack_ptr - need + count > STACK_DEPTH)
				view.status = STATUS_OVERFLOW;
			else begin
				base = stack_ptr - need;
				for (int k = 0; k < count; k++)
					stack_slots[base + count - 1 - k] = cand[order[k]];
				stack_ptr = base + count;
			end
		end
		view.top_value = (stack_ptr != 0) ? stack_slots[stack_ptr - 1].value : '0;
		view.top_is_wide = (stack_ptr != 0) ? stack_slots[stack_ptr - 1].wide : 1'b0;
		view.stack_depth = DEPTH_W'(stack_ptr);
		return view;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_t       pushed;
		stack_view_t got;
		stack_view_t want;
		if (!arst_n) begin
			stack_ptr = 0;
			expected_views.delete();
			pending_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pushed.value = s_axis_tdata[CMD_W +: VALUE_W];
				pushed.wide = s_axis_tuser;
				expected_views.push_back(execute_command(s_axis_tdata[CMD_W-1:0], pushed));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.top_value = m_axis_tdata[VALUE_W-1:0];
				got.stack_depth = m_axis_tdata[VALUE_W +: DEPTH_W];
				got.status = status_t'(m_axis_tdata[VALUE_W + DEPTH_W +: 2]);
				got.top_is_wide = m_axis_tuser;
				if (expected_views.size() == 0)
					report_mismatch("result with no command pending, top_value",
							got.top_value, '0);
				else begin
					want = expected_views.pop_front();
					if (got.top_value !== want.top_value)
						report_mismatch("top_value", got.top_value, want.top_value);
					if (got.top_is_wide !== want.top_is_wide)
						report_mismatch("top_is_wide", VALUE_W'(got.top_is_wide),
								VALUE_W'(want.top_is_wide));
					if (got.stack_depth !== want.stack_depth)
						report_mismatch("stack_depth", VALUE_W'(got.stack_depth),
								VALUE_W'(want.stack_depth));
					if (got.status !== want.status)
						report_mismatch("status", VALUE_W'(got.status),
								VALUE_W'(want.status));
				end
			end
			pending_count <= expected_views.size();
		end
	end

endmodule

// File: tb/sv/jvm_operand_stack_shuffle_top_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives stack command transactions into the operand stack unit.
module jvm_operand_stack_shuffle_top_tb;
	import jvmoss_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int RANDOM_ITEMS = 950;
	localparam int IDLE_PERCENT = 7;
	localparam int STEADY_FIRST = 400;
	localparam int STEADY_LAST = 650;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd10;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 4'd15;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tuser;
	int                error_count;
	int                pending_count;
	bit                steady = 1'b0;
	int                quiet_cycles = 0;

	always #6 clk = ~clk;

	jvm_operand_stack_shuffle_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	jvm_operand_stack_shuffle_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.error_count  (error_count),
		.pending_count(pending_count)
	);

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("jvm_operand_stack_shuffle_top_tb: errors");
			$finish;
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] code,
			input logic [VALUE_W-1:0] value, input logic wide);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(DATA_W - CMD_W - VALUE_W){1'b0}}, value, code};
		s_axis_tuser <= wide;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	initial begin
		int               phase_left;
		int               push_percent;
		int               pop_percent;
		int               pick;
		logic [CMD_W-1:0] code;
		logic [VALUE_W-1:0] value;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: underflow, missing slots and an unused code; then every shuffle command.
		send_command(CMD_POP, '0, 1'b0);
		send_command(CMD_POP2, '0, 1'b0);
		send_command(CMD_DUP2_X2, '1, 1'b1);
		send_command(CMD_SPARE_LAST, '1, 1'b1);
		send_command(CMD_PUSH, '0, 1'b0);
		send_command(CMD_DUP_X1, '0, 1'b0);
		send_command(CMD_PUSH, '1, 1'b1);
		send_command(CMD_DUP, '0, 1'b0);
		send_command(CMD_DUP2, '0, 1'b0);
		send_command(CMD_PUSH, {$urandom, $urandom}, 1'b0);
		send_command(CMD_SWAP, '0, 1'b0);
		send_command(CMD_DUP_X1, '0, 1'b0);
		send_command(CMD_DUP_X2, '0, 1'b0);
		send_command(CMD_PUSH, {$urandom, $urandom}, 1'b0);
		send_command(CMD_DUP2_X1, '0, 1'b0);
		send_command(CMD_DUP2_X2, '0, 1'b0);
		send_command(CMD_DUP2, '0, 1'b0);
		send_command(CMD_PUSH, {$urandom, $urandom}, 1'b0);
		// Filling the last slots and then trying to grow past them.
		send_command(CMD_PUSH, '1, 1'b1);
		send_command(CMD_PUSH, '0, 1'b0);
		send_command(CMD_DUP, '0, 1'b0);
		send_command(CMD_POP2, '0, 1'b0);
		send_command(CMD_PUSH, {$urandom, $urandom}, 1'b0);
		send_command(CMD_POP2, '0, 1'b0);
		send_command(CMD_SPARE_FIRST, '0, 1'b0);

		// Phases that grow, shrink or hold the stack, so that both ends are reached often.
		phase_left = 0;
		push_percent = 0;
		pop_percent = 0;
		for (int item = 0; item < RANDOM_ITEMS; item++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(50, 15);
				case ($urandom_range(2))
					0: begin
						push_percent = 50; pop_percent = 10;
					end
					1: begin
						push_percent = 10; pop_percent = 60;
					end
					default: begin
						push_percent = 20; pop_percent = 35;
					end
				endcase
			end
			phase_left--;
			steady <= (item >= STEADY_FIRST && item < STEADY_LAST);
			pick = $urandom_range(99);
			if (pick < push_percent)
				code = CMD_PUSH;
			else if (pick < push_percent + pop_percent)
				code = $urandom_range(1) ? CMD_POP : CMD_POP2;
			else if ($urandom_range(99) < 4)
				code = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			else
				code = CMD_W'($urandom_range(CMD_SWAP, CMD_POP));
			value = ($urandom_range(15) == 0) ? {VALUE_W{$urandom_range(1) == 1}}
					: {$urandom, $urandom};
			send_command(code, value, 1'($urandom_range(1)));
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("jvm_operand_stack_shuffle_top_tb: clean");
		else
			$display("jvm_operand_stack_shuffle_top_tb: errors");
		$finish;
	end

endmodule

// File: jvm_operand_stack_shuffle_top.f
src/jvmoss_pkg.sv
src/jvm_operand_stack_shuffle_top.sv
tb/sv/jvm_operand_stack_shuffle_checker.sv
tb/sv/jvm_operand_stack_shuffle_top_tb.sv
